>>> hdl/haversine_distance_macros.svh
// Assertion macros for the checker file of the distance block.
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define HVD_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define HVD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define HVD_CHECK_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hvd_pkg.sv
`default_nettype none

package hvd_pkg;

  // Default arithmetic precision and CORDIC depth.
  localparam int FRACTION_BITS_DEF = 30;
  localparam int CORDIC_ROUNDS_DEF = 32;

  // Field widths of the ports.
  localparam int LAT_W  = 24;
  localparam int LON_W  = 25;
  localparam int DIST_W = 25;

  // Pi with 60 fraction bits, and pi/180 with 61 fraction bits.
  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] DEG_Q61 = 64'h6487ED5110B4611A / 64'd180;

  // The degree constant is 56 bits wide and is multiplied in two halves.
  localparam int          DEG_SPLIT = 28;
  localparam logic [27:0] DEG_LO    = DEG_Q61[27:0];
  localparam logic [27:0] DEG_HI    = DEG_Q61[55:28];

  // CORDIC start gain in units of 1e-18.
  localparam logic [63:0] GAIN_E18 = 64'd607252935008881256;
  localparam logic [63:0] TEN_E18  = 64'd1000000000000000000;

  // Twice the earth radius in meters.
  localparam int          TWO_R_W      = 24;
  localparam logic [23:0] TWO_R_METERS = 24'd12742000;

  // Cycles from the input of the sine/cosine unit to its registered result.
  function automatic int sc_latency(input int rounds);
    return rounds + 7;
  endfunction

  // Shift-subtract long division of a 128-bit value, optionally rounded.
  function automatic logic [63:0] long_div(input logic [127:0] num, input logic [63:0] den,
                                           input logic rnd);
    logic [64:0] rem;
    logic [63:0] q;
    int k;
    rem = '0;
    q   = '0;
    for (k = 127; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      q   = {q[62:0], 1'b0};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    if (rnd && (rem >= ({1'b0, den} - rem))) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  // Pi and pi/2 with f fraction bits, rounded.
  function automatic logic [63:0] pi_q(input int f);
    return (PI_Q60 + (64'd1 << (59 - f))) >> (60 - f);
  endfunction

  function automatic logic [63:0] half_pi_q(input int f);
    return (PI_Q60 + (64'd1 << (60 - f))) >> (61 - f);
  endfunction

  // atan(2^-i) with f fraction bits, from the Q62 power series.
  function automatic logic [63:0] atan_q(input int i, input int f);
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] acc;
    int n;
    int e;
    acc = '0;
    if (i == 0) begin
      s = PI_Q60;
    end else begin
      for (n = 0; n < 32; n++) begin
        e = 62 - i * (2 * n + 1);
        if (e >= 0) begin
          t = long_div({64'd0, 64'd1 << e}, 64'(2 * n + 1), 1'b0);
          if (n[0]) begin
            acc = acc - t;
          end else begin
            acc = acc + t;
          end
        end
      end
      s = acc;
    end
    return (s + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // Rotation-mode start gain with f fraction bits.
  function automatic logic [63:0] gain_q(input int f);
    return long_div({64'd0, GAIN_E18} << f, TEN_E18, 1'b1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/haversine_distance.sv
`default_nettype none

// Great-circle distance between two points given in degrees with 16 fraction
// bits, in whole meters on a sphere of radius 6371 km, by the haversine
// formula in fixed point with FRACTION_BITS fraction bits. The block is a
// single pipeline that takes one item per cycle while the output is not
// stalled and returns one result per item, in order. Its stages are 7 plus
// one per round in the sine/cosine CORDIC, three multiply and sum stages,
// one stage per root bit in the two square roots, one stage per round in
// the arcsine CORDIC, and two for the scaling to meters. A result that is
// not taken holds the whole pipeline, so input ready is low only while the
// output register is full and stalled.
module haversine_distance #(
  parameter int FRACTION_BITS = hvd_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_ROUNDS = hvd_pkg::CORDIC_ROUNDS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [hvd_pkg::LAT_W-1:0]  in_first_latitude,
  input  wire logic signed [hvd_pkg::LON_W-1:0]  in_first_longitude,
  input  wire logic signed [hvd_pkg::LAT_W-1:0]  in_second_latitude,
  input  wire logic signed [hvd_pkg::LON_W-1:0]  in_second_longitude,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [hvd_pkg::DIST_W-1:0]             out_distance_meters
);

  localparam int F      = FRACTION_BITS;
  localparam int N      = CORDIC_ROUNDS;
  localparam int W      = F + 3;
  localparam int SW     = 2 * F + 3;
  localparam int SC_LAT = hvd_pkg::sc_latency(N);
  localparam int TOTAL  = SC_LAT + 3 + (F + 1) + N + 2;
  localparam int DLAT_W = hvd_pkg::LAT_W + 1;
  localparam int DLON_W = hvd_pkg::LON_W + 1;
  localparam int DW     = hvd_pkg::DIST_W;
  localparam int PDW    = W - 1 + hvd_pkg::TWO_R_W;

  localparam logic [F:0]          ONE_U  = {1'b1, {F{1'b0}}};
  localparam logic signed [W:0]   ONE_S  = $signed((W + 1)'(ONE_U));
  localparam logic [DW-1:0]       D_MAX  = {DW{1'b1}};

  // Rounded fixed-point product, half away from zero on the magnitude.
  function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] p;
    logic [W-1:0]   r;
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    p  = (2 * W)'(ma) * (2 * W)'(mb) + ((2 * W)'(1) << (F - 1));
    r  = W'(p >> F);
    return (a[W-1] ^ b[W-1]) ? -$signed(r) : $signed(r);
  endfunction

  logic                     en;
  logic [TOTAL-1:0]         vld_r;
  logic signed [DLAT_W-1:0] dlat;
  logic signed [DLON_W-1:0] dlon;
  logic signed [W-1:0]      s1;
  logic signed [W-1:0]      s2;
  logic signed [W-1:0]      c1;
  logic signed [W-1:0]      c2;

  logic signed [W-1:0]      sq1_r;
  logic signed [W-1:0]      sq2_r;
  logic signed [W-1:0]      cc_r;
  logic signed [W-1:0]      sq1d_r;
  logic signed [W-1:0]      pr_r;
  logic signed [W:0]        asum;
  logic [F:0]               aclamp;

  logic [SW-1:0]            remx_r  [0:F+1];
  logic [SW-1:0]            remy_r  [0:F+1];
  logic [F:0]               rootx_r [0:F+1];
  logic [F:0]               rooty_r [0:F+1];

  logic signed [W-1:0]      vx_r [1:N];
  logic signed [W-1:0]      vy_r [1:N];
  logic signed [W-1:0]      vz_r [1:N];

  logic                     zneg_r;
  logic [PDW-1:0]           dprod_r;
  logic [PDW-1:0]           drnd;
  logic [DW-1:0]            dist_r;

  // The pipeline moves whenever the output register is free or being read.
  assign en       = !vld_r[TOTAL-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid};
    end
  end

  // Half differences and absolute latitudes go to four sine/cosine units.
  assign dlat = DLAT_W'(in_second_latitude) - DLAT_W'(in_first_latitude);
  assign dlon = DLON_W'(in_second_longitude) - DLON_W'(in_first_longitude);

  hvd_sincos #(
    .FRACTION_BITS(F), .CORDIC_ROUNDS(N), .DEG_W(DLAT_W), .HALF_ANGLE(1), .USE_COS(0)
  ) u_sin_dlat (
    .clk(clk), .en(en), .deg(dlat), .val(s1)
  );

  hvd_sincos #(
    .FRACTION_BITS(F), .CORDIC_ROUNDS(N), .DEG_W(DLON_W), .HALF_ANGLE(1), .USE_COS(0)
  ) u_sin_dlon (
    .clk(clk), .en(en), .deg(dlon), .val(s2)
  );

  hvd_sincos #(
    .FRACTION_BITS(F), .CORDIC_ROUNDS(N), .DEG_W(hvd_pkg::LAT_W), .HALF_ANGLE(0),
    .USE_COS(1)
  ) u_cos_lat1 (
    .clk(clk), .en(en), .deg(in_first_latitude), .val(c1)
  );

  hvd_sincos #(
    .FRACTION_BITS(F), .CORDIC_ROUNDS(N), .DEG_W(hvd_pkg::LAT_W), .HALF_ANGLE(0),
    .USE_COS(1)
  ) u_cos_lat2 (
    .clk(clk), .en(en), .deg(in_second_latitude), .val(c2)
  );

  // Squares and the cosine product, then the second product.
  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r  <= qmul(s1, s1);
      sq2_r  <= qmul(s2, s2);
      cc_r   <= qmul(c1, c2);
      pr_r   <= qmul(cc_r, sq2_r);
      sq1d_r <= sq1_r;
    end
  end

  // Sum and clamp to [0, 1].
  assign asum = (W + 1)'(sq1d_r) + (W + 1)'(pr_r);

  always_comb begin
    priority if (asum < 0) begin
      aclamp = '0;
    end else if (asum > ONE_S) begin
      aclamp = ONE_U;
    end else begin
      aclamp = asum[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0]  <= SW'(ONE_U - aclamp) << F;
      remy_r[0]  <= SW'(aclamp) << F;
      rootx_r[0] <= '0;
      rooty_r[0] <= '0;
    end
  end

  // Two square roots, one result bit per stage from the top bit down.
  for (genvar j = 0; j <= F; j++) begin : g_sqrt
    localparam int B = F - j;
    logic [SW-1:0] trx;
    logic [SW-1:0] try_v;

    assign trx   = (SW'(rootx_r[j]) << (B + 1)) + (SW'(1) << (2 * B));
    assign try_v = (SW'(rooty_r[j]) << (B + 1)) + (SW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (remx_r[j] >= trx) begin
          remx_r[j+1]  <= remx_r[j] - trx;
          rootx_r[j+1] <= rootx_r[j] | ((F + 1)'(1) << B);
        end else begin
          remx_r[j+1]  <= remx_r[j];
          rootx_r[j+1] <= rootx_r[j];
        end
        if (remy_r[j] >= try_v) begin
          remy_r[j+1]  <= remy_r[j] - try_v;
          rooty_r[j+1] <= rooty_r[j] | ((F + 1)'(1) << B);
        end else begin
          remy_r[j+1]  <= remy_r[j];
          rooty_r[j+1] <= rooty_r[j];
        end
      end
    end
  end

  // Vectoring CORDIC: the angle of (sqrt(1-a), sqrt(a)) is the arcsine.
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [W-1:0] AT = W'(hvd_pkg::atan_q(i, F));
    logic signed [W-1:0] xi;
    logic signed [W-1:0] yi;
    logic signed [W-1:0] zi;

    if (i == 0) begin : g_first
      assign xi = $signed(W'(rootx_r[F+1]));
      assign yi = $signed(W'(rooty_r[F+1]));
      assign zi = '0;
    end else begin : g_next
      assign xi = vx_r[i];
      assign yi = vy_r[i];
      assign zi = vz_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[W-1]) begin
          vx_r[i+1] <= xi + (yi >>> i);
          vy_r[i+1] <= yi - (xi >>> i);
          vz_r[i+1] <= zi + AT;
        end else begin
          vx_r[i+1] <= xi - (yi >>> i);
          vy_r[i+1] <= yi + (xi >>> i);
          vz_r[i+1] <= zi - AT;
        end
      end
    end
  end

  // Scale the half angle by the diameter, round and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      zneg_r  <= vz_r[N][W-1];
      dprod_r <= PDW'(vz_r[N][W-2:0]) * PDW'(hvd_pkg::TWO_R_METERS);
    end
  end

  assign drnd = (dprod_r + (PDW'(1) << (F - 1))) >> F;

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (zneg_r) begin
        dist_r <= '0;
      end else if (drnd > PDW'(D_MAX)) begin
        dist_r <= D_MAX;
      end else begin
        dist_r <= DW'(drnd);
      end
    end
  end

  assign out_valid           = vld_r[TOTAL-1];
  assign out_distance_meters = dist_r;

endmodule

`default_nettype wire

>>> hdl/hvd_sincos.sv
`default_nettype none

// Degrees to radians, folding by pi and a pipelined rotation CORDIC.
// Gives the sine or the cosine of the angle, or of half of it, one stage per rotation.
module hvd_sincos #(
  parameter int FRACTION_BITS = hvd_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_ROUNDS = hvd_pkg::CORDIC_ROUNDS_DEF,
  parameter int DEG_W         = 26,
  parameter int HALF_ANGLE    = 0,
  parameter int USE_COS       = 0
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic signed [DEG_W-1:0]        deg,
  output logic signed [FRACTION_BITS+2:0]     val
);

  localparam int F    = FRACTION_BITS;
  localparam int N    = CORDIC_ROUNDS;
  localparam int W    = F + 3;
  localparam int TW   = F + 4;
  localparam int S    = 77 - F + HALF_ANGLE;
  localparam int SPL  = hvd_pkg::DEG_SPLIT;
  localparam int PRW  = DEG_W + SPL;
  localparam int PW   = DEG_W + 2 * SPL + 1;

  localparam logic signed [TW-1:0] PI_F    = TW'(hvd_pkg::pi_q(F));
  localparam logic signed [TW-1:0] HALF_PI = TW'(hvd_pkg::half_pi_q(F));
  localparam logic signed [W-1:0]  GAIN    = W'(hvd_pkg::gain_q(F));

  logic [DEG_W-1:0] mag;
  logic [PRW-1:0]   p_hi_r;
  logic [PRW-1:0]   p_lo_r;
  logic             neg_r;
  logic [PW-1:0]    full;
  logic [TW-1:0]    tmag;

  logic signed [TW-1:0] fth_r [0:4];
  logic                 ffl_r [0:4];

  logic signed [W-1:0]  x_r  [1:N];
  logic signed [W-1:0]  y_r  [1:N];
  logic signed [TW-1:0] z_r  [1:N];
  logic                 fl_r [1:N];

  logic signed [W-1:0]  val_r;

  // Magnitude times pi/180, in two partial products.
  assign mag = deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi_r <= PRW'(mag) * PRW'(hvd_pkg::DEG_HI);
      p_lo_r <= PRW'(mag) * PRW'(hvd_pkg::DEG_LO);
      neg_r  <= deg[DEG_W-1];
    end
  end

  // Join the partial products, round half away from zero and restore the sign.
  assign full = (PW'(p_hi_r) << SPL) + PW'(p_lo_r) + (PW'(1) << (S - 1));
  assign tmag = TW'(full >> S);

  always_ff @(posedge clk) begin
    if (en) begin
      fth_r[0] <= neg_r ? -$signed(tmag) : $signed(tmag);
      ffl_r[0] <= 1'b0;
    end
  end

  // Four folding steps bring the angle into [-pi/2, pi/2].
  for (genvar k = 0; k < 4; k++) begin : g_fold
    always_ff @(posedge clk) begin
      if (en) begin
        priority if (fth_r[k] > HALF_PI) begin
          fth_r[k+1] <= fth_r[k] - PI_F;
          ffl_r[k+1] <= !ffl_r[k];
        end else if (fth_r[k] < -HALF_PI) begin
          fth_r[k+1] <= fth_r[k] + PI_F;
          ffl_r[k+1] <= !ffl_r[k];
        end else begin
          fth_r[k+1] <= fth_r[k];
          ffl_r[k+1] <= ffl_r[k];
        end
      end
    end
  end

  // One rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [TW-1:0] AT = TW'(hvd_pkg::atan_q(i, F));
    logic signed [W-1:0]  xi;
    logic signed [W-1:0]  yi;
    logic signed [TW-1:0] zi;
    logic                 fi;

    if (i == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = fth_r[4];
      assign fi = ffl_r[4];
    end else begin : g_next
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign zi = z_r[i];
      assign fi = fl_r[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[TW-1]) begin
          x_r[i+1] <= xi - (yi >>> i);
          y_r[i+1] <= yi + (xi >>> i);
          z_r[i+1] <= zi - AT;
        end else begin
          x_r[i+1] <= xi + (yi >>> i);
          y_r[i+1] <= yi - (xi >>> i);
          z_r[i+1] <= zi + AT;
        end
        fl_r[i+1] <= fi;
      end
    end
  end

  // Pick sine or cosine and undo the fold.
  always_ff @(posedge clk) begin
    if (en) begin
      if (USE_COS != 0) begin
        val_r <= fl_r[N] ? -x_r[N] : x_r[N];
      end else begin
        val_r <= fl_r[N] ? -y_r[N] : y_r[N];
      end
    end
  end

  assign val = val_r;

endmodule

`default_nettype wire

>>> hdl/hvd_checker.sv
`default_nettype none

`include "haversine_distance_macros.svh"

// Port-level checks of the distance block.
module hvd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [24:0] out_distance_meters
);

  // A result that is not taken stays, unchanged.
  `HVD_CHECK_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HVD_CHECK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_distance_meters), "result changed")

  // The input side is open whenever the output register can move.
  `HVD_CHECK_SAME(a_ready_free, !out_valid || out_ready, in_ready, "input blocked with free output")

  // Reset empties the pipeline.
  `HVD_CHECK_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result present after reset")

endmodule

bind haversine_distance hvd_checker u_hvd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_distance_meters(out_distance_meters)
);

`default_nettype wire
